>>> sv/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// Checks that a consequent sequence follows an antecedent outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed: implication does not hold");

`endif

>>> sv/mwg_pkg.sv
// Package of the multi-waveform generator: defaults, codes and the sine table entry function.
`timescale 1ns / 1ps
`default_nettype none

package mwg_pkg;

   localparam int DEF_PHASE_BITS = 16;
   localparam int DEF_TABLE_BITS = 10;
   localparam int DEF_OUT_BITS   = 16;

   localparam int MODE_BITS    = 3;
   localparam int PW_BITS      = 17;
   localparam int CSR_IDX_BITS = 2;
   localparam int PW_FRAC_BITS = 16;

   // Taylor coefficients of sin(pi/2 * t) in Q30.
   localparam logic [63:0] COEF_A = 64'd1686629713;
   localparam logic [63:0] COEF_B = 64'd693598668;
   localparam logic [63:0] COEF_C = 64'd85569306;
   localparam logic [63:0] COEF_D = 64'd5026995;
   localparam logic [63:0] COEF_E = 64'd172272;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SINE     = 3'd0,
      MODE_COSINE   = 3'd1,
      MODE_SAWTOOTH = 3'd2,
      MODE_TRIANGLE = 3'd3,
      MODE_SQUARE   = 3'd4,
      MODE_PULSE    = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BIPOLAR     = 2'd0,
      CSR_INVERT_WAVE = 2'd1,
      CSR_PULSE_WIDTH = 2'd2
   } csr_index_type;

   // One quarter-wave sine entry, evaluated at elaboration only.
   function automatic logic [63:0] rom_entry(input int idx, input int tb, input int ob);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] p;
      logic [63:0] v;
      logic [63:0] r;
      int          sh;
      sh = 30 - (ob - 1);
      t  = (64'(idx) << 30) >> tb;
      u  = (t * t) >> 30;
      p  = COEF_E;
      p  = COEF_D - ((u * p) >> 30);
      p  = COEF_C - ((u * p) >> 30);
      p  = COEF_B - ((u * p) >> 30);
      p  = COEF_A - ((u * p) >> 30);
      v  = (t * p) >> 30;
      r  = (v + (64'd1 << (sh - 1))) >> sh;
      if (r > (64'd1 << (ob - 1))) begin
         r = 64'd1 << (ob - 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/multi_waveform_generator.sv
// Top level of the multi-waveform generator: a four-stage sample pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                    Handshake
// request   in         req_phase, req_mode                      start high, busy low
// response  out        rsp_sample                               rsp_strobe, one cycle
// csr       in         csr_index, csr_wdata                     csr_we, no wait
//
// One word is accepted in every clock cycle; busy is high only during reset.
// The response is registered through the stages address, sine table
// read, sign and pulse compare, and range mapping, each one register stage.
// Reset is synchronous, clears the valid bits and sets the control registers to their defaults.
// The receiver cannot stall the pipeline, so no stage ever holds or repeats.

module multi_waveform_generator
   import mwg_pkg::*;
#(
   parameter int PHASE_BITS = DEF_PHASE_BITS,
   parameter int TABLE_BITS = DEF_TABLE_BITS,
   parameter int OUT_BITS   = DEF_OUT_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [PHASE_BITS-1:0]         req_phase,
   input  wire logic [MODE_BITS-1:0]          req_mode,
   output logic                               rsp_strobe,
   output logic signed [OUT_BITS-1:0]         rsp_sample,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [PW_BITS-1:0]            csr_wdata
);

   // Sine table geometry: a quarter wave with both end points stored.
   localparam int ROM_N = 1 << TABLE_BITS;
   localparam int AW    = TABLE_BITS + 1;
   localparam int KW    = TABLE_BITS + 2;

   // Shifts that take the phase to the table index.
   localparam int KSH = PHASE_BITS - KW;
   localparam int KL  = (KSH < 0) ? -KSH : 0;
   localparam int KR  = (KSH > 0) ? KSH : 0;
   localparam int KXW = PHASE_BITS + KL;

   // Shifts that scale a phase fraction to full scale.
   localparam int DSH = PHASE_BITS - (OUT_BITS - 1);
   localparam int LSH = (DSH < 0) ? -DSH : 0;
   localparam int RSH = (DSH > 0) ? DSH : 0;
   localparam int TXW = PHASE_BITS + 1 + LSH;

   localparam int CW = OUT_BITS + PW_FRAC_BITS + 1;
   localparam int VW = OUT_BITS + 2;

   localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
   localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(1) << (PHASE_BITS - 1);
   localparam logic [PHASE_BITS:0]   CYCLE   = (PHASE_BITS + 1)'(1) << PHASE_BITS;
   localparam logic [AW-1:0]         ROM_TOP = AW'(1) << TABLE_BITS;
   localparam logic [OUT_BITS-1:0]   FULL    = OUT_BITS'(1) << (OUT_BITS - 1);
   localparam logic [OUT_BITS:0]     FULL_W  = (OUT_BITS + 1)'(1) << (OUT_BITS - 1);
   localparam logic signed [VW-1:0]  FULL_V  = VW'(1) <<< (OUT_BITS - 1);
   localparam logic signed [VW-1:0]  MAX_V   = FULL_V - VW'(1);

   typedef logic [OUT_BITS-1:0] rom_type [0:ROM_N];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i <= ROM_N; i++) begin
         rom[i] = OUT_BITS'(rom_entry(i, TABLE_BITS, OUT_BITS));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Configuration registers. The user must change them only while the pipeline
   // is empty, which the block does not enforce; each stage reads them directly.
   logic                bipolar_ff;
   logic                invert_ff;
   logic [PW_BITS-1:0]  pulse_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bipolar_ff     <= 1'b1;
         invert_ff      <= 1'b0;
         pulse_width_ff <= PW_BITS'(1) << (PW_FRAC_BITS - 1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIPOLAR:     bipolar_ff     <= csr_wdata[0];
            CSR_INVERT_WAVE: invert_ff      <= csr_wdata[0];
            CSR_PULSE_WIDTH: pulse_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: table address, quadrant, and the unipolar value of the
   // shapes that come straight from the phase.
   mode_type            mode_in;
   logic [PHASE_BITS-1:0] sine_phase_in;
   logic [KXW-1:0]      k_wide_in;
   logic [KW-1:0]       k_in;
   logic [TABLE_BITS-1:0] j_in;
   logic [AW-1:0]       addr_in;
   logic [PHASE_BITS:0] tri_t_in;
   logic [PHASE_BITS:0] mirror_in;
   logic [TXW-1:0]      saw_wide_in;
   logic [TXW-1:0]      tri_wide_in;
   logic [OUT_BITS-1:0] r1_in;

   always_comb begin
      mode_in       = mode_type'(req_mode);
      sine_phase_in = (mode_in == MODE_COSINE) ? req_phase + QUARTER : req_phase;
      k_wide_in     = (KXW'(sine_phase_in) << KL) >> KR;
      k_in          = k_wide_in[KW-1:0];
      j_in          = k_in[TABLE_BITS-1:0];
      // Odd quadrants read the table mirrored.
      addr_in       = k_in[KW-2] ? ROM_TOP - {1'b0, j_in} : {1'b0, j_in};
      mirror_in     = CYCLE - {1'b0, req_phase};
      tri_t_in      = (req_phase < HALF) ? {req_phase, 1'b0} : (mirror_in << 1);
      saw_wide_in   = (TXW'(req_phase) << LSH) >> RSH;
      tri_wide_in   = (TXW'(tri_t_in) << LSH) >> RSH;
      unique case (mode_in)
         MODE_SAWTOOTH: r1_in = saw_wide_in[OUT_BITS-1:0];
         MODE_TRIANGLE: r1_in = tri_wide_in[OUT_BITS-1:0];
         MODE_SQUARE:   r1_in = (req_phase <= HALF) ? FULL : '0;
         default:       r1_in = '0;
      endcase
   end

   logic                s1_valid_ff;
   mode_type            s1_mode_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic                s1_neg_ff;
   logic [OUT_BITS-1:0] s1_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_mode_ff <= mode_in;
      s1_addr_ff <= addr_in;
      s1_neg_ff  <= k_in[KW-1];
      s1_r_ff    <= r1_in;
   end

   // Stage 2: registered read of the sine table.
   logic                s2_valid_ff;
   mode_type            s2_mode_ff;
   logic                s2_neg_ff;
   logic [OUT_BITS-1:0] s2_r_ff;
   logic [OUT_BITS-1:0] s2_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mode_ff <= s1_mode_ff;
      s2_neg_ff  <= s1_neg_ff;
      s2_r_ff    <= s1_r_ff;
      s2_mag_ff  <= SINE_ROM[s1_addr_ff];
   end

   // Stage 3: signed sine and the exact pulse threshold compare.
   logic signed [OUT_BITS:0] s3_s_in;
   logic [OUT_BITS:0]        us_in;
   logic [CW-1:0]            lhs_in;
   logic [CW-1:0]            rhs_in;
   logic [OUT_BITS-1:0]      r3_in;

   always_comb begin
      s3_s_in = s2_neg_ff ? -$signed({1'b0, s2_mag_ff}) : $signed({1'b0, s2_mag_ff});
      us_in   = s2_neg_ff ? FULL_W - {1'b0, s2_mag_ff} : FULL_W + {1'b0, s2_mag_ff};
      lhs_in  = CW'(us_in) << PW_FRAC_BITS;
      rhs_in  = CW'(pulse_width_ff) << OUT_BITS;
      r3_in   = (s2_mode_ff == MODE_PULSE) ? ((lhs_in < rhs_in) ? '0 : FULL) : s2_r_ff;
   end

   logic                     s3_valid_ff;
   mode_type                 s3_mode_ff;
   logic signed [OUT_BITS:0] s3_s_ff;
   logic [OUT_BITS-1:0]      s3_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_mode_ff <= s2_mode_ff;
      s3_s_ff    <= s3_s_in;
      s3_r_ff    <= r3_in;
   end

   // Stage 4: invert, range mapping and saturation of +1.0.
   logic signed [VW-1:0] sine_in;
   logic signed [VW-1:0] rr_in;
   logic signed [VW-1:0] v_in;
   logic signed [OUT_BITS-1:0] sample_in;

   always_comb begin
      sine_in = invert_ff ? -VW'(s3_s_ff) : VW'(s3_s_ff);
      rr_in   = invert_ff ? FULL_V - VW'({1'b0, s3_r_ff}) : VW'({1'b0, s3_r_ff});
      unique case (s3_mode_ff)
         MODE_SINE, MODE_COSINE: begin
            v_in = bipolar_ff ? sine_in : ((sine_in + FULL_V) >>> 1);
         end
         MODE_SAWTOOTH, MODE_TRIANGLE, MODE_SQUARE, MODE_PULSE: begin
            v_in = bipolar_ff ? (rr_in <<< 1) - FULL_V : rr_in;
         end
         default: begin
            v_in = '0;
         end
      endcase
      priority if (v_in > MAX_V) begin
         sample_in = MAX_V[OUT_BITS-1:0];
      end else if (v_in < -FULL_V) begin
         sample_in = FULL;
      end else begin
         sample_in = v_in[OUT_BITS-1:0];
      end
   end

   logic                       rsp_strobe_ff;
   logic signed [OUT_BITS-1:0] rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s3_valid_ff;
      end
      rsp_sample_ff <= sample_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

>>> sv/mwg_checker.sv
// Port-level checker of the multi-waveform generator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwg_checker
   import mwg_pkg::*;
#(
   parameter int PHASE_BITS = DEF_PHASE_BITS,
   parameter int OUT_BITS   = DEF_OUT_BITS
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_strobe,
   input wire logic [OUT_BITS-1:0]     rsp_sample,
   input wire logic                    csr_we,
   input wire logic [CSR_IDX_BITS-1:0] csr_index,
   input wire logic [PW_BITS-1:0]      csr_wdata
);

   // Shadow of the range register, taken from the write port.
   logic bipolar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bipolar_ff <= 1'b1;
      end else if (csr_we && (csr_index_type'(csr_index) == CSR_BIPOLAR)) begin
         bipolar_ff <= csr_wdata[0];
      end
   end

   logic accept;
   assign accept = start && !busy;

   // Every accepted word yields its sample on the response strobe.
   `ASSERT_IMPLIES(a_latency, clock, reset, accept, ##4 rsp_strobe)
   // No sample appears without a word accepted before it.
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_strobe, $past(accept, 4))
   // In unipolar range a sample is never negative.
   `ASSERT_IMPLIES(a_unipolar, clock, reset, rsp_strobe && !bipolar_ff, !rsp_sample[OUT_BITS-1])
   // The pipeline never refuses a word outside reset.
   `ASSERT_ALWAYS(a_no_stall, clock, reset, !busy)

endmodule

bind multi_waveform_generator mwg_checker #(
   .PHASE_BITS(PHASE_BITS),
   .OUT_BITS(OUT_BITS)
) u_mwg_checker (.*);

`default_nettype wire
